// ----- design/cem_pkg.sv -----
// shared types and constants for the charge and energy meter
package cem_pkg;

   // tick rate of the measurement stream
   localparam int unsigned TICKS_PER_SECOND = 100;
   localparam int unsigned PRESCALE_W       = 7;

   // field widths
   localparam int unsigned CMD_W       = 2;
   localparam int unsigned VOLT_W      = 20;
   localparam int unsigned CURR_W      = 18;
   localparam int unsigned TARGET_W    = 21;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned CHARGE_W    = 48;
   localparam int unsigned ENERGY_W    = 63;
   localparam int unsigned PROD_W      = VOLT_W + 1 + CURR_W;
   localparam int unsigned POWER_MAG_W = PROD_W - 1;

   // packed stream widths
   localparam int unsigned REQ_FIELDS_W = VOLT_W + CURR_W;
   localparam int unsigned REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int unsigned RSP_FIELDS_W = 1 + 2 * COUNT_W + 2 * CHARGE_W + 2 * ENERGY_W;
   localparam int unsigned RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_VOLTAGE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CV_ENABLE      = 1'd1;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK      = 2'd0,
      CMD_BEGIN_RUN = 2'd1,
      CMD_END_RUN   = 2'd2
   } cmd_type;

endpackage

// ----- design/charge_energy_meter_core.sv -----
// top level of the battery charge and energy meter
// an accepted req passes the input stage, then the update stage that drives rsp
// throughput: one transaction per cycle unless stalled; voltage times current is
//    registered in the input stage, the saturating adds run in the update stage
// reset: synchronous, active high; clears run flag, prescaler, all counts and sums,
//    the pipeline valid bits and both configuration registers
module charge_energy_meter_core (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write port
   input  logic                              csr_wr_en,
   input  logic [cem_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cem_pkg::TARGET_W-1:0]      csr_wdata,
   // measurement stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // voltage_mv [19:0], current_ma [37:20], zero [39:38]
   input  logic [cem_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command [1:0]
   input  logic [cem_pkg::CMD_W-1:0]         req_tuser,
   // meter state stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // running [0], run_seconds [32:1], cv_ticks [64:33], charge_mas [112:65],
   // discharge_mas [160:113], charge_energy_uws [223:161],
   // discharge_energy_uws [286:224], zero [287]
   output logic [cem_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam logic [cem_pkg::COUNT_W-1:0]  MAX_COUNT  = '1;
   localparam logic [cem_pkg::CHARGE_W-1:0] MAX_CHARGE = '1;
   localparam logic [cem_pkg::ENERGY_W-1:0] MAX_ENERGY = '1;
   localparam logic [cem_pkg::PRESCALE_W-1:0] PRESCALE_TOP =
      cem_pkg::PRESCALE_W'(cem_pkg::TICKS_PER_SECOND);

   // configuration registers
   logic signed [cem_pkg::TARGET_W-1:0] target_ff;
   logic                                cv_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         cv_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            cem_pkg::CSR_TARGET_VOLTAGE: target_ff    <= csr_wdata;
            cem_pkg::CSR_CV_ENABLE:      cv_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // input stage: unpack, split current into sign and magnitude, multiply
   // ------------------------------------------------------------------
   logic [cem_pkg::VOLT_W-1:0]         req_voltage;
   logic signed [cem_pkg::CURR_W-1:0]  req_current;
   logic signed [cem_pkg::PROD_W-1:0]  req_power;
   logic signed [cem_pkg::PROD_W-1:0]  req_power_neg;
   logic signed [cem_pkg::CURR_W:0]    req_current_neg;

   assign req_voltage     = req_tdata[cem_pkg::VOLT_W-1:0];
   assign req_current     = req_tdata[cem_pkg::REQ_FIELDS_W-1:cem_pkg::VOLT_W];
   // voltage is unsigned, so it gets a zero sign bit before the signed multiply
   assign req_power       = $signed({1'b0, req_voltage}) *
                            $signed({{(cem_pkg::VOLT_W+1){req_current[cem_pkg::CURR_W-1]}},
                                     req_current});
   assign req_power_neg   = -req_power;
   assign req_current_neg = -$signed({req_current[cem_pkg::CURR_W-1], req_current});

   logic                                 s1_valid_ff;
   cem_pkg::cmd_type                     s1_cmd_ff;
   logic [cem_pkg::VOLT_W-1:0]           s1_voltage_ff;
   logic                                 s1_cur_pos_ff;
   logic [cem_pkg::CURR_W-1:0]           s1_cur_mag_ff;
   logic                                 s1_pwr_pos_ff;
   logic [cem_pkg::POWER_MAG_W-1:0]      s1_pwr_mag_ff;

   // the update stage moves whenever the result slot is free or being drained
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_cmd_ff     <= cem_pkg::cmd_type'(req_tuser);
         s1_voltage_ff <= req_voltage;
         s1_cur_pos_ff <= (req_current > 0);
         // zero or negative current goes to discharge as its magnitude
         s1_cur_mag_ff <= (req_current > 0) ? req_current : req_current_neg[cem_pkg::CURR_W-1:0];
         s1_pwr_pos_ff <= (req_power > 0);
         s1_pwr_mag_ff <= (req_power > 0) ? req_power[cem_pkg::POWER_MAG_W-1:0]
                                          : req_power_neg[cem_pkg::POWER_MAG_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // update stage: meter state doubles as the result register
   // ------------------------------------------------------------------
   logic                              run_ff,       run_in;
   logic [cem_pkg::PRESCALE_W-1:0]    prescale_ff,  prescale_in;
   logic [cem_pkg::COUNT_W-1:0]       seconds_ff,   seconds_in;
   logic [cem_pkg::COUNT_W-1:0]       cv_ff,        cv_in;
   logic [cem_pkg::CHARGE_W-1:0]      chg_ff,       chg_in;
   logic [cem_pkg::CHARGE_W-1:0]      dis_ff,       dis_in;
   logic [cem_pkg::ENERGY_W-1:0]      chg_e_ff,     chg_e_in;
   logic [cem_pkg::ENERGY_W-1:0]      dis_e_ff,     dis_e_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic                              take;
   logic                              cv_hit;
   logic [cem_pkg::PRESCALE_W-1:0]    prescale_inc;
   logic [cem_pkg::CHARGE_W:0]        chg_sum, dis_sum;
   logic [cem_pkg::ENERGY_W:0]        chg_e_sum, dis_e_sum;

   assign take = s1_valid_ff && advance;

   // unsigned voltage against signed target, both widened to a common signed form
   assign cv_hit = $signed({2'b00, s1_voltage_ff}) >=
                   $signed({target_ff[cem_pkg::TARGET_W-1], target_ff});

   assign prescale_inc = prescale_ff + 1'b1;

   // one extra bit catches the carry for saturation
   assign chg_sum   = {1'b0, chg_ff} +
                      (cem_pkg::CHARGE_W+1)'(s1_cur_mag_ff);
   assign dis_sum   = {1'b0, dis_ff} +
                      (cem_pkg::CHARGE_W+1)'(s1_cur_mag_ff);
   assign chg_e_sum = {1'b0, chg_e_ff} +
                      (cem_pkg::ENERGY_W+1)'(s1_pwr_mag_ff);
   assign dis_e_sum = {1'b0, dis_e_ff} +
                      (cem_pkg::ENERGY_W+1)'(s1_pwr_mag_ff);

   always_comb begin
      run_in       = run_ff;
      prescale_in  = prescale_ff;
      seconds_in   = seconds_ff;
      cv_in        = cv_ff;
      chg_in       = chg_ff;
      dis_in       = dis_ff;
      chg_e_in     = chg_e_ff;
      dis_e_in     = dis_e_ff;
      rsp_valid_in = rsp_valid_ff;

      if (advance) begin
         rsp_valid_in = s1_valid_ff;
      end

      if (take) begin
         case (s1_cmd_ff)
            cem_pkg::CMD_BEGIN_RUN: begin
               // restart: prescaler keeps its phase
               run_in     = 1'b1;
               seconds_in = '0;
               cv_in      = '0;
            end
            cem_pkg::CMD_END_RUN: begin
               run_in = 1'b0;
            end
            cem_pkg::CMD_TICK: begin
               if (run_ff) begin
                  if (cv_enable_ff && cv_hit && (cv_ff != MAX_COUNT)) begin
                     cv_in = cv_ff + 1'b1;
                  end
                  prescale_in = prescale_inc;
                  // one second of run time is complete
                  if (prescale_inc >= PRESCALE_TOP) begin
                     prescale_in = '0;
                     if (seconds_ff != MAX_COUNT) begin
                        seconds_in = seconds_ff + 1'b1;
                     end
                     if (s1_cur_pos_ff) begin
                        chg_in = chg_sum[cem_pkg::CHARGE_W] ? MAX_CHARGE
                                                            : chg_sum[cem_pkg::CHARGE_W-1:0];
                     end else begin
                        dis_in = dis_sum[cem_pkg::CHARGE_W] ? MAX_CHARGE
                                                            : dis_sum[cem_pkg::CHARGE_W-1:0];
                     end
                     if (s1_pwr_pos_ff) begin
                        chg_e_in = chg_e_sum[cem_pkg::ENERGY_W] ? MAX_ENERGY
                                                                : chg_e_sum[cem_pkg::ENERGY_W-1:0];
                     end else begin
                        dis_e_in = dis_e_sum[cem_pkg::ENERGY_W] ? MAX_ENERGY
                                                                : dis_e_sum[cem_pkg::ENERGY_W-1:0];
                     end
                  end
               end
            end
            default: ;   // unused command code leaves the state alone
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         prescale_ff  <= '0;
         seconds_ff   <= '0;
         cv_ff        <= '0;
         chg_ff       <= '0;
         dis_ff       <= '0;
         chg_e_ff     <= '0;
         dis_e_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         prescale_ff  <= prescale_in;
         seconds_ff   <= seconds_in;
         cv_ff        <= cv_in;
         chg_ff       <= chg_in;
         dis_ff       <= dis_in;
         chg_e_ff     <= chg_e_in;
         dis_e_ff     <= dis_e_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // state only moves when a new result enters the slot, so it holds while stalled
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, dis_e_ff, chg_e_ff, dis_ff, chg_ff, cv_ff, seconds_ff, run_ff};

endmodule
